@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ hw/rtl/mfp_pkg.sv @@
package mfp_pkg;

   localparam logic [7:0]  START_BYTE     = 8'hFE;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [7:0]  ID_POSITION    = 8'd33;
   localparam logic [7:0]  ID_ACK         = 8'd77;
   localparam logic [7:0]  ALT_OFFSET     = 8'd16;
   localparam logic [7:0]  POS_EXTRA_RST  = 8'd104;
   localparam logic [7:0]  ACK_EXTRA_RST  = 8'd143;

   localparam int unsigned CAP_SLOTS      = 7;
   localparam int unsigned CSR_IDX_W      = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_POS_EXTRA = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_EXTRA = 4'd1;

   localparam logic KIND_ALTITUDE = 1'b0;
   localparam logic KIND_ACK      = 1'b1;

   // One byte of CRC-16/MCRF4XX (reflected 0x1021).
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'h0};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b0_0000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

endpackage

@@ hw/rtl/mavlink_frame_parser.sv @@
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_valid / req_ready | req_rx_byte[7:0]
// rsp      | out       | rsp_valid / rsp_ready | rsp_result_kind, rsp_altitude_mm[31:0],
//          |           |                       | rsp_acked_command[15:0], rsp_ack_code[7:0]
// csr      | in        | csr_valid / csr_ready | csr_index[3:0], csr_wdata[7:0]
//
// One byte is taken per cycle while req_ready is high: the parse state, CRC and
// capture slots update at the accepting edge, and the second CRC byte's verdict lands in
// the output register, so a result appears in the cycle after the last CRC byte is accepted.
// req_ready drops only while the output register is full and rsp_ready is low.
// Synchronous active-high reset returns to hunting, clears the CRC state and the
// captured payload bytes, and restores both CRC extra bytes; csr_ready is always high.
`include "assert_macros.svh"

module mavlink_frame_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_result_kind,
   output logic signed [31:0]               rsp_altitude_mm,
   output logic [15:0]                      rsp_acked_command,
   output logic [7:0]                       rsp_ack_code,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mfp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                       csr_wdata
);

   typedef enum logic [3:0] {
      PH_START   = 4'd0,
      PH_LEN     = 4'd1,
      PH_SEQ     = 4'd2,
      PH_SYS     = 4'd3,
      PH_COMP    = 4'd4,
      PH_ID      = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CRCLO   = 4'd7,
      PH_CRCHI   = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  cap_ff [mfp_pkg::CAP_SLOTS];
   logic [7:0]  pos_extra_ff, ack_extra_ff;

   logic        cap_we;
   logic [2:0]  cap_slot;
   logic [7:0]  pos_next;
   logic [7:0]  extra;
   logic [15:0] crc_final;
   logic        crc_ok;
   logic        res_load;
   logic        res_kind;
   logic        accept;

   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [31:0] rsp_alt_ff;
   logic [15:0] rsp_cmd_ff;
   logic [7:0]  rsp_code_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign pos_next  = pos_ff + 8'd1;

   always_comb begin
      extra = 8'h00;
      if (id_ff == mfp_pkg::ID_POSITION) begin
         extra = pos_extra_ff;
      end else if (id_ff == mfp_pkg::ID_ACK) begin
         extra = ack_extra_ff;
      end
   end

   assign crc_final = mfp_pkg::crc_step(crc_ff, extra);
   assign crc_ok    = crc_final == {req_rx_byte, crc_lo_ff};

   // Capture slot: bytes 0..2 to slots 0..2, bytes 16..19 to slots 3..6.
   always_comb begin
      cap_we   = 1'b0;
      cap_slot = pos_ff[2:0];
      if (pos_ff < 8'd3) begin
         cap_we = 1'b1;
      end else if (pos_ff[7:2] == mfp_pkg::ALT_OFFSET[7:2]) begin
         cap_we   = 1'b1;
         cap_slot = 3'd3 + {1'b0, pos_ff[1:0]};
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      id_in     = id_ff;
      pos_in    = pos_ff;
      crc_lo_in = crc_lo_ff;
      crc_in    = crc_ff;
      res_load  = 1'b0;
      res_kind  = mfp_pkg::KIND_ALTITUDE;
      unique case (phase_ff)
         PH_LEN: begin
            crc_in   = mfp_pkg::crc_step(crc_ff, req_rx_byte);
            len_in   = req_rx_byte;
            phase_in = PH_SEQ;
         end
         PH_SEQ: begin
            crc_in   = mfp_pkg::crc_step(crc_ff, req_rx_byte);
            phase_in = PH_SYS;
         end
         PH_SYS: begin
            crc_in   = mfp_pkg::crc_step(crc_ff, req_rx_byte);
            phase_in = PH_COMP;
         end
         PH_COMP: begin
            crc_in   = mfp_pkg::crc_step(crc_ff, req_rx_byte);
            phase_in = PH_ID;
         end
         PH_ID: begin
            crc_in   = mfp_pkg::crc_step(crc_ff, req_rx_byte);
            id_in    = req_rx_byte;
            pos_in   = 8'd0;
            phase_in = (len_ff != 8'd0) ? PH_PAYLOAD : PH_CRCLO;
         end
         PH_PAYLOAD: begin
            crc_in = mfp_pkg::crc_step(crc_ff, req_rx_byte);
            pos_in = pos_next;
            if (pos_next >= len_ff) begin
               phase_in = PH_CRCLO;
            end
         end
         PH_CRCLO: begin
            crc_lo_in = req_rx_byte;
            phase_in  = PH_CRCHI;
         end
         PH_CRCHI: begin
            phase_in = PH_START;
            if (crc_ok && id_ff == mfp_pkg::ID_POSITION) begin
               res_load = 1'b1;
               res_kind = mfp_pkg::KIND_ALTITUDE;
            end else if (crc_ok && id_ff == mfp_pkg::ID_ACK) begin
               res_load = 1'b1;
               res_kind = mfp_pkg::KIND_ACK;
            end
         end
         default: begin
            // Hunt for the start byte; stray phase codes land here too.
            phase_in = PH_START;
            if (req_rx_byte == mfp_pkg::START_BYTE) begin
               crc_in   = mfp_pkg::CRC_INIT;
               phase_in = PH_LEN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         len_ff       <= 8'd0;
         id_ff        <= 8'd0;
         pos_ff       <= 8'd0;
         crc_lo_ff    <= 8'd0;
         crc_ff       <= 16'd0;
         for (int i = 0; i < mfp_pkg::CAP_SLOTS; i++) begin
            cap_ff[i] <= 8'd0;
         end
         pos_extra_ff <= mfp_pkg::POS_EXTRA_RST;
         ack_extra_ff <= mfp_pkg::ACK_EXTRA_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               mfp_pkg::CSR_POS_EXTRA: pos_extra_ff <= csr_wdata;
               mfp_pkg::CSR_ACK_EXTRA: ack_extra_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff  <= phase_in;
            len_ff    <= len_in;
            id_ff     <= id_in;
            pos_ff    <= pos_in;
            crc_lo_ff <= crc_lo_in;
            crc_ff    <= crc_in;
            if (phase_ff == PH_PAYLOAD && cap_we) begin
               cap_ff[cap_slot] <= req_rx_byte;
            end
         end
         if (accept && res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: no reset needed.
   always_ff @(posedge clock) begin
      if (accept && res_load) begin
         rsp_kind_ff <= res_kind;
         if (res_kind == mfp_pkg::KIND_ALTITUDE) begin
            rsp_alt_ff  <= {cap_ff[6], cap_ff[5], cap_ff[4], cap_ff[3]};
            rsp_cmd_ff  <= 16'd0;
            rsp_code_ff <= 8'd0;
         end else begin
            rsp_alt_ff  <= 32'd0;
            rsp_cmd_ff  <= {cap_ff[1], cap_ff[0]};
            rsp_code_ff <= cap_ff[2];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_altitude_mm   = $signed(rsp_alt_ff);
   assign rsp_acked_command = rsp_cmd_ff;
   assign rsp_ack_code      = rsp_code_ff;

   `ASSERT_CLK(a_load_on_crchi, clock, reset, res_load |-> phase_ff == PH_CRCHI, "result outside CRC check")
   `ASSERT_CLK(a_payload_in_range, clock, reset, phase_ff == PH_PAYLOAD |-> pos_ff < len_ff, "payload position past length")
   `ASSERT_CLK(a_alt_zero_ack, clock, reset, (rsp_valid_ff && rsp_kind_ff == mfp_pkg::KIND_ALTITUDE) |-> (rsp_cmd_ff == 16'd0 && rsp_code_ff == 8'd0), "altitude item carries ack fields")
   `ASSERT_NEVER(a_stall_only_full, clock, reset, !req_ready && !(rsp_valid_ff && !rsp_ready), "input stalled with room")

endmodule
